// File: rtl/core/coap_response_parser_top_macros.svh
// Assertion macros shared by the CoAP response parser checkers.
`ifndef COAP_RESPONSE_PARSER_TOP_MACROS_SVH
`define COAP_RESPONSE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/crp_pkg.sv
// Shared widths, status codes and protocol constants of the CoAP response parser.
package crp_pkg;

	localparam int unsigned MAX_FRAME_DEF = 2048;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 12;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned OBL_W    = 17;

	// Frame status codes reported with the last word of a datagram.
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_VERSION = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CODE    = 3'd4;

	// Protocol constants.
	localparam logic [BYTE_W-1:0] MARKER_BYTE  = 8'hFF;
	localparam logic [3:0]        NIB_EXT1     = 4'd13;
	localparam logic [3:0]        NIB_EXT2     = 4'd14;
	localparam logic [OBL_W-1:0]  EXT1_BASE    = 17'd13;
	localparam logic [OBL_W-1:0]  EXT2_BASE    = 17'd269;
	localparam logic [1:0]        HDR_VERSION  = 2'd1;
	localparam logic [2:0]        CLASS_OK     = 3'd2;

endpackage

// File: rtl/core/coap_response_parser_top.sv
// CoAP response parser: walks header, token, options and emits payload bytes.
// A byte accepted into the input register moves on to the result register when that register can take a word.
// Throughput: one datagram byte per cycle while result words are taken.
// A waiting result word stalls the input once the input register holds a word.
// Reset (arst_n low) clears the pipeline valids and the parse state; no frame is open.
module coap_response_parser_top
	import crp_pkg::*;
#(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                frame_start,
	input  logic [LEN_W-1:0]    frame_length,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [BYTE_W-1:0]   payload_byte,
	output logic                payload_valid,
	output logic                frame_done,
	output logic [STATUS_W-1:0] status
);

	localparam int unsigned LEN_MAX   = (1 << LEN_W) - 1;
	localparam int unsigned CLAMP_LEN = (MAX_FRAME > LEN_MAX) ? LEN_MAX : MAX_FRAME;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_OPT,
		PH_DEXT,
		PH_LEXT,
		PH_SKIP,
		PH_MARKER,
		PH_PAYLOAD,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [1:0]       dext;
		logic [OBL_W-1:0] obl;
	} stage_t;

	// Option value: skip it, go to the next option, or give up when it does not fit.
	function automatic stage_t value_stage(input logic [OBL_W-1:0] opt_len,
		input logic [LEN_W-1:0] rem, input stage_t cur);
		stage_t r;
		r = cur;
		if (opt_len > OBL_W'(rem)) begin
			r.phase = PH_MARKER;
		end else if (opt_len == '0) begin
			r.phase = PH_OPT;
		end else begin
			r.obl   = opt_len;
			r.phase = PH_SKIP;
		end
		return r;
	endfunction

	// Option length nibble: extension bytes or the value directly.
	function automatic stage_t length_stage(input logic [3:0] nib,
		input logic [LEN_W-1:0] rem, input stage_t cur);
		stage_t r;
		r = cur;
		if (nib == NIB_EXT1) begin
			if (rem < LEN_W'(1)) begin
				r.phase = PH_MARKER;
			end else begin
				r.dext  = 2'd1;
				r.phase = PH_LEXT;
			end
		end else if (nib == NIB_EXT2) begin
			if (rem < LEN_W'(2)) begin
				r.phase = PH_MARKER;
			end else begin
				r.dext  = 2'd2;
				r.phase = PH_LEXT;
			end
		end else begin
			r = value_stage(OBL_W'(nib), rem, cur);
		end
		return r;
	endfunction

	// Input register.
	logic                valid_s1;
	logic [BYTE_W-1:0]   data_byte_s1;
	logic                frame_start_s1;
	logic [LEN_W-1:0]    frame_length_s1;

	// Parse state.
	phase_t              phase_q;
	logic [LEN_W-1:0]    pos_q;
	logic [LEN_W-1:0]    len_q;
	logic [3:0]          tok_q;
	logic [OBL_W-1:0]    obl_q;
	logic [1:0]          dext_q;
	logic [3:0]          nib_q;
	logic [BYTE_W-1:0]   hi_q;
	logic [STATUS_W-1:0] fstat_q;

	// Result register.
	logic                result_valid_q;
	logic [BYTE_W-1:0]   payload_byte_q;
	logic                payload_valid_q;
	logic                frame_done_q;
	logic [STATUS_W-1:0] status_q;

	logic                advance;
	logic                fire;

	// Next-state and result signals.
	logic                active;
	logic [LEN_W-1:0]    len_in;
	logic [LEN_W-1:0]    cur_len;
	logic [LEN_W-1:0]    cur_pos;
	logic [LEN_W-1:0]    rem;
	stage_t              st;
	logic [3:0]          tok_d;
	logic [3:0]          nib_d;
	logic [BYTE_W-1:0]   hi_d;
	logic [STATUS_W-1:0] fstat_d;
	logic [LEN_W-1:0]    pos_d;
	logic [LEN_W-1:0]    len_d;
	logic                emit;
	logic                last;
	logic                give_result;
	logic [BYTE_W-1:0]   b;

	// Handshake: the input stage moves whenever the result register can take a word.
	assign advance    = !result_valid_q || result_ready;
	assign byte_ready = !valid_s1 || advance;
	assign fire       = valid_s1 && advance;
	assign b          = data_byte_s1;

	// Per-byte parse step.
	always_comb begin
		if (frame_length_s1 == '0) begin
			len_in = LEN_W'(1);
		end else if (frame_length_s1 > LEN_W'(CLAMP_LEN)) begin
			len_in = LEN_W'(CLAMP_LEN);
		end else begin
			len_in = frame_length_s1;
		end

		if (frame_start_s1) begin
			cur_len   = len_in;
			cur_pos   = '0;
			st.phase  = PH_HEADER;
			st.dext   = '0;
			st.obl    = '0;
			tok_d     = '0;
			nib_d     = '0;
			hi_d      = '0;
			fstat_d   = ST_OK;
		end else begin
			cur_len   = len_q;
			cur_pos   = pos_q;
			st.phase  = phase_q;
			st.dext   = dext_q;
			st.obl    = obl_q;
			tok_d     = tok_q;
			nib_d     = nib_q;
			hi_d      = hi_q;
			fstat_d   = fstat_q;
		end
		active = frame_start_s1 || (len_q != '0);
		rem    = cur_len - LEN_W'(1) - cur_pos;
		emit   = 1'b0;

		unique case (st.phase)
			PH_HEADER: begin
				if (cur_pos == LEN_W'(0)) begin
					if (cur_len < LEN_W'(4)) begin
						fstat_d  = ST_SHORT;
						st.phase = PH_DRAIN;
					end else if (b[7:6] != HDR_VERSION) begin
						fstat_d  = ST_VERSION;
						st.phase = PH_DRAIN;
					end else begin
						tok_d = b[3:0];
					end
				end else if (cur_pos == LEN_W'(1)) begin
					if (b[7:5] != CLASS_OK) begin
						fstat_d  = (b == '0) ? ST_EMPTY : ST_CODE;
						st.phase = PH_DRAIN;
					end
				end else if (cur_pos == LEN_W'(3)) begin
					if (tok_d != '0 && LEN_W'(tok_d) <= rem) begin
						st.obl   = OBL_W'(tok_d);
						st.phase = PH_SKIP;
					end else begin
						st.phase = PH_OPT;
					end
				end
			end
			PH_OPT: begin
				if (b == MARKER_BYTE) begin
					st.phase = PH_PAYLOAD;
				end else begin
					nib_d = b[3:0];
					if (b[7:4] == NIB_EXT1) begin
						if (rem < LEN_W'(1)) begin
							st.phase = PH_MARKER;
						end else begin
							st.dext  = 2'd1;
							st.phase = PH_DEXT;
						end
					end else if (b[7:4] == NIB_EXT2) begin
						if (rem < LEN_W'(2)) begin
							st.phase = PH_MARKER;
						end else begin
							st.dext  = 2'd2;
							st.phase = PH_DEXT;
						end
					end else begin
						st = length_stage(b[3:0], rem, st);
					end
				end
			end
			PH_DEXT: begin
				st.dext = st.dext - 2'd1;
				if (st.dext == 2'd0) begin
					st = length_stage(nib_d, rem, st);
				end
			end
			PH_LEXT: begin
				if (nib_d == NIB_EXT2 && st.dext == 2'd2) begin
					hi_d    = b;
					st.dext = 2'd1;
				end else begin
					st.dext = 2'd0;
					if (nib_d == NIB_EXT2) begin
						st = value_stage(EXT2_BASE + OBL_W'({hi_d, b}), rem, st);
					end else begin
						st = value_stage(EXT1_BASE + OBL_W'(b), rem, st);
					end
				end
			end
			PH_SKIP: begin
				st.obl = st.obl - OBL_W'(1);
				if (st.obl == '0) begin
					st.phase = PH_OPT;
				end
			end
			PH_MARKER: begin
				st.phase = PH_PAYLOAD;
				emit     = (b != MARKER_BYTE);
			end
			PH_PAYLOAD: begin
				emit = 1'b1;
			end
			PH_DRAIN: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		last        = (rem == '0);
		give_result = active && (emit || last);
		if (last) begin
			len_d = '0;
			pos_d = '0;
		end else begin
			len_d = cur_len;
			pos_d = cur_pos + LEN_W'(1);
		end
	end

	// Pipeline, parse state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			phase_q        <= PH_HEADER;
			pos_q          <= '0;
			len_q          <= '0;
			tok_q          <= '0;
			obl_q          <= '0;
			dext_q         <= '0;
			nib_q          <= '0;
			hi_q           <= '0;
			fstat_q        <= ST_OK;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (advance) begin
				result_valid_q <= fire && give_result;
			end
			if (fire && active) begin
				phase_q <= st.phase;
				pos_q   <= pos_d;
				len_q   <= len_d;
				tok_q   <= tok_d;
				obl_q   <= st.obl;
				dext_q  <= st.dext;
				nib_q   <= nib_d;
				hi_q    <= hi_d;
				fstat_q <= fstat_d;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_byte_s1    <= data_byte;
			frame_start_s1  <= frame_start;
			frame_length_s1 <= frame_length;
		end
		if (fire && give_result) begin
			payload_byte_q  <= emit ? b : '0;
			payload_valid_q <= emit;
			frame_done_q    <= last;
			status_q        <= last ? fstat_d : ST_OK;
		end
	end

	assign result_valid  = result_valid_q;
	assign payload_byte  = payload_byte_q;
	assign payload_valid = payload_valid_q;
	assign frame_done    = frame_done_q;
	assign status        = status_q;

endmodule

// File: rtl/core/crp_checker.sv
// Port-level checker for the CoAP response parser and its bind to the top level.
`include "coap_response_parser_top_macros.svh"

module crp_checker
	import crp_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_ready,
	input logic [BYTE_W-1:0]   payload_byte,
	input logic                payload_valid,
	input logic                frame_done,
	input logic [STATUS_W-1:0] status
);

	// A stalled result word holds its contents.
	`CRP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(payload_byte) && $stable(frame_done) && $stable(status), "stalled result word changed")

	// Status is only reported on the last word of a datagram.
	`CRP_ASSERT_IMPL(a_status_on_done, clk, arst_n, result_valid && !frame_done, status == ST_OK, "status set on a word that does not end a frame")

	// A word without payload carries a zero byte, and every result word has a reason.
	`CRP_ASSERT_IMPL(a_payload_zero, clk, arst_n, result_valid && !payload_valid, payload_byte == '0 && frame_done, "empty result word is malformed")

	// Rejected frames never deliver payload on their last word.
	`CRP_ASSERT_IMPL(a_error_no_payload, clk, arst_n, result_valid && frame_done && status != ST_OK, !payload_valid, "payload delivered on a rejected frame")

endmodule

bind coap_response_parser_top crp_checker u_crp_checker (.*);
